// ----- src/triangle_tangent_from_uv_defines.svh -----
// assertion macros shared by the tangent block
// no dependencies; included by the top level only
`ifndef TRIANGLE_TANGENT_FROM_UV_DEFINES_SVH
`define TRIANGLE_TANGENT_FROM_UV_DEFINES_SVH

// implication checked on every clock edge out of reset
`define TFUV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication whose consequent is checked in the next cycle
`define TFUV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tfuv_pkg.sv -----
// shared types and constants for the triangle tangent block
// no dependencies
`timescale 1ns / 1ps

package tfuv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW = 32;   // field width
  localparam int DW = 33;   // difference width
  localparam int PW = 66;   // product width
  localparam int SW = 67;   // difference of two products
  localparam int QW = 32;   // quotient bits produced

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] tex_u;
    logic signed [CW-1:0] tex_v;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] tangent_x;
    logic signed [CW-1:0] tangent_y;
    logic signed [CW-1:0] tangent_z;
    logic [1:0]           corner_slot;
    logic                 degenerate;
    logic                 last_of_triangle;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;
    logic [1:0] load_idx;
    logic       diff;
    logic       dmul;
    logic       dsub;
    logic       nmul;
    logic       nsub;
    logic       dchk;
    logic       dstep;
    logic       wr;
    logic       emit;
    logic [1:0] slot;
    logic [1:0] comp;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic det_zero;
    logic out_free;
  } sts_t;

  localparam logic [1:0] SLOT_LAST = 2'd2;
  localparam logic [1:0] COMP_LAST = 2'd2;

endpackage

// ----- src/triangle_tangent_from_uv.sv -----
// top level of the per-triangle tangent block: controller plus datapath
// depends on tfuv_pkg, tfuv_ctrl, tfuv_dp and triangle_tangent_from_uv_defines.svh
//
//   channel  dir  valid        stall        payload
//   in       in   in_valid_i   in_stall_o   in_data_i  (one corner)
//   out      out  out_valid_o  out_stall_i  out_data_o (one tangent)
//
// the first two corners of a triangle are stored; the third starts three slots:
// 3 setup steps, then per component the numerator products, a subtract, a divider
// check, the one-bit-a-cycle divider and a write, then an emit step
// a slot with zero determinant skips the divider and the other component steps
// reset clears the controller and the output valid; corner store is not cleared
// a stalled output holds the next slot at its emit step; the last tangent may
// wait while the next corner is accepted
`timescale 1ns / 1ps
`include "triangle_tangent_from_uv_defines.svh"

module triangle_tangent_from_uv #(
  parameter int FRAC_BITS = tfuv_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tfuv_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tfuv_pkg::out_t out_data_o
);
  import tfuv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tfuv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic
  tfuv_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // checks on own logic
  `TFUV_ASSERT_IMP(a_last_flag, out_valid_o, out_data_o.last_of_triangle == (out_data_o.corner_slot == SLOT_LAST), "last flag does not match slot")
  `TFUV_ASSERT_IMP(a_degen_zero, out_valid_o && out_data_o.degenerate, out_data_o.tangent_x == '0 && out_data_o.tangent_y == '0 && out_data_o.tangent_z == '0, "degenerate tangent not zero")
  `TFUV_ASSERT_NEXT(a_emit_free, cmd.emit, out_valid_o, "emitted tangent not presented")
  `TFUV_ASSERT_IMP(a_no_emit_busy, cmd.emit, sts.out_free, "emit while output occupied")

endmodule

// ----- src/tfuv_ctrl.sv -----
// sequencer for the tangent block: corner counting and per-slot steps
// depends on tfuv_pkg
`timescale 1ns / 1ps

module tfuv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tfuv_pkg::sts_t sts_i,
  output tfuv_pkg::cmd_t cmd_o
);
  import tfuv_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DIFF = 4'd1;
  localparam logic [3:0] ST_DMUL = 4'd2;
  localparam logic [3:0] ST_DSUB = 4'd3;
  localparam logic [3:0] ST_NMUL = 4'd4;
  localparam logic [3:0] ST_NSUB = 4'd5;
  localparam logic [3:0] ST_DCHK = 4'd6;
  localparam logic [3:0] ST_DIV  = 4'd7;
  localparam logic [3:0] ST_WR   = 4'd8;
  localparam logic [3:0] ST_EMIT = 4'd9;

  localparam int STEPW = $clog2(QW);

  logic [3:0]       state_q, state_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [1:0]       slot_q, slot_d;
  logic [1:0]       comp_q, comp_d;
  logic [STEPW-1:0] step_q, step_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    slot_d     = slot_q;
    comp_d     = comp_q;
    step_d     = step_q;
    cmd_o      = '0;
    cmd_o.slot = slot_q;
    cmd_o.comp = comp_q;
    cmd_o.load_idx = cnt_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (cnt_q == SLOT_LAST) begin
            cnt_d   = '0;
            slot_d  = '0;
            state_d = ST_DIFF;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_DMUL;
      end
      ST_DMUL: begin
        cmd_o.dmul = 1'b1;
        state_d    = ST_DSUB;
      end
      ST_DSUB: begin
        cmd_o.dsub = 1'b1;
        comp_d     = '0;
        state_d    = ST_NMUL;
      end
      ST_NMUL: begin
        if (sts_i.det_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.nmul = 1'b1;
          state_d    = ST_NSUB;
        end
      end
      ST_NSUB: begin
        cmd_o.nsub = 1'b1;
        state_d    = ST_DCHK;
      end
      ST_DCHK: begin
        cmd_o.dchk = 1'b1;
        step_d     = STEPW'(QW - 1);
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.dstep = 1'b1;
        step_d      = step_q - 1'b1;
        if (step_q == '0) state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        if (comp_q == COMP_LAST) begin
          state_d = ST_EMIT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_NMUL;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (slot_q == SLOT_LAST) begin
            state_d = ST_IDLE;
          end else begin
            slot_d  = slot_q + 2'd1;
            state_d = ST_DIFF;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      slot_q  <= '0;
      comp_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      slot_q  <= slot_d;
      comp_q  <= comp_d;
      step_q  <= step_d;
    end
  end

endmodule

// ----- src/tfuv_dp.sv -----
// datapath: corner store, differences, products, serial divider, output register
// depends on tfuv_pkg
`timescale 1ns / 1ps

module tfuv_dp #(
  parameter int FRAC_BITS = tfuv_pkg::FRAC_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tfuv_pkg::in_t  in_data_i,
  input  tfuv_pkg::cmd_t cmd_i,
  output tfuv_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tfuv_pkg::out_t out_data_o
);
  import tfuv_pkg::*;

  localparam int NW = SW + FRAC_BITS;  // shifted numerator
  localparam int HW = NW - QW;         // part above the quotient bits
  localparam int RW = SW + 1;          // remainder

  in_t c0_q, c1_q, c2_q;
  in_t ca, cb, cc;

  logic signed [DW-1:0] d1u_q, d1v_q, d2u_q, d2v_q;
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [DW-1:0] e1s, e2s;
  logic signed [PW-1:0] p1_q, p2_q;
  logic signed [SW-1:0] sum;
  logic [SW-1:0]        det_mag_q, num_mag_q;
  logic                 det_neg_q, det_zero_q, num_neg_q;
  logic [NW-1:0]        nfull;
  logic [HW-1:0]        nhi;
  logic [RW-1:0]        rem_q, rem_t;
  logic [QW-1:0]        lo_q, q_q;
  logic                 ovf_q, ge;
  logic                 neg;
  logic [QW-1:0]        limit, mag, res;
  logic signed [CW-1:0] tx_q, ty_q, tz_q;
  logic                 out_valid_q;
  out_t                 out_q;

  // corner store
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (cmd_i.load_idx)
        2'd0:    c0_q <= in_data_i;
        2'd1:    c1_q <= in_data_i;
        default: c2_q <= in_data_i;
      endcase
    end
  end

  // rotate corners for the base slot
  always_comb begin
    case (cmd_i.slot)
      2'd0:    begin ca = c0_q; cb = c1_q; cc = c2_q; end
      2'd1:    begin ca = c1_q; cb = c2_q; cc = c0_q; end
      default: begin ca = c2_q; cb = c0_q; cc = c1_q; end
    endcase
  end

  // component select for numerator products
  always_comb begin
    case (cmd_i.comp)
      2'd0:    begin e1s = e1_q[0]; e2s = e2_q[0]; end
      2'd1:    begin e1s = e1_q[1]; e2s = e2_q[1]; end
      default: begin e1s = e1_q[2]; e2s = e2_q[2]; end
    endcase
  end

  // edge and uv differences
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      d1u_q   <= {cb.tex_u[CW-1], cb.tex_u} - {ca.tex_u[CW-1], ca.tex_u};
      d1v_q   <= {cb.tex_v[CW-1], cb.tex_v} - {ca.tex_v[CW-1], ca.tex_v};
      d2u_q   <= {cc.tex_u[CW-1], cc.tex_u} - {ca.tex_u[CW-1], ca.tex_u};
      d2v_q   <= {cc.tex_v[CW-1], cc.tex_v} - {ca.tex_v[CW-1], ca.tex_v};
      e1_q[0] <= {cb.pos_x[CW-1], cb.pos_x} - {ca.pos_x[CW-1], ca.pos_x};
      e1_q[1] <= {cb.pos_y[CW-1], cb.pos_y} - {ca.pos_y[CW-1], ca.pos_y};
      e1_q[2] <= {cb.pos_z[CW-1], cb.pos_z} - {ca.pos_z[CW-1], ca.pos_z};
      e2_q[0] <= {cc.pos_x[CW-1], cc.pos_x} - {ca.pos_x[CW-1], ca.pos_x};
      e2_q[1] <= {cc.pos_y[CW-1], cc.pos_y} - {ca.pos_y[CW-1], ca.pos_y};
      e2_q[2] <= {cc.pos_z[CW-1], cc.pos_z} - {ca.pos_z[CW-1], ca.pos_z};
    end
  end

  // two shared multipliers
  always_ff @(posedge clk_i) begin
    if (cmd_i.dmul) begin
      p1_q <= d1u_q * d2v_q;
      p2_q <= d2u_q * d1v_q;
    end else if (cmd_i.nmul) begin
      p1_q <= d2v_q * e1s;
      p2_q <= d1v_q * e2s;
    end
  end

  assign sum = {p1_q[PW-1], p1_q} - {p2_q[PW-1], p2_q};

  // determinant and numerator magnitude and sign
  always_ff @(posedge clk_i) begin
    if (cmd_i.dsub) begin
      det_neg_q  <= sum[SW-1];
      det_mag_q  <= sum[SW-1] ? SW'(-sum) : SW'(sum);
      det_zero_q <= (sum == '0);
    end
    if (cmd_i.nsub) begin
      num_neg_q <= sum[SW-1];
      num_mag_q <= sum[SW-1] ? SW'(-sum) : SW'(sum);
    end
  end

  assign nfull = {num_mag_q, {FRAC_BITS{1'b0}}};
  assign nhi   = nfull[NW-1:QW];
  assign rem_t = {rem_q[RW-2:0], lo_q[QW-1]};
  assign ge    = (rem_t >= RW'(det_mag_q));

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.dchk) begin
      ovf_q <= (RW'(nhi) >= RW'(det_mag_q));
      rem_q <= RW'(nhi);
      lo_q  <= nfull[QW-1:0];
      q_q   <= '0;
    end else if (cmd_i.dstep) begin
      rem_q <= ge ? (rem_t - RW'(det_mag_q)) : rem_t;
      lo_q  <= {lo_q[QW-2:0], 1'b0};
      q_q   <= {q_q[QW-2:0], ge};
    end
  end

  // sign and saturation of one component
  assign neg   = num_neg_q ^ det_neg_q;
  assign limit = neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  assign mag   = (ovf_q || (q_q > limit)) ? limit : q_q;
  assign res   = neg ? (~mag + 1'b1) : mag;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      case (cmd_i.comp)
        2'd0:    tx_q <= res;
        2'd1:    ty_q <= res;
        default: tz_q <= res;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.tangent_x        <= det_zero_q ? '0 : tx_q;
      out_q.tangent_y        <= det_zero_q ? '0 : ty_q;
      out_q.tangent_z        <= det_zero_q ? '0 : tz_q;
      out_q.corner_slot      <= cmd_i.slot;
      out_q.degenerate       <= det_zero_q;
      out_q.last_of_triangle <= (cmd_i.slot == SLOT_LAST);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.det_zero  = det_zero_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

// ----- test/tb_triangle_tangent_from_uv.sv -----
// testbench for triangle_tangent_from_uv: random and directed corners, tangents checked
// against a behavioral tangent predictor; depends on tfuv_pkg and the block's rtl
`timescale 1ns / 1ps

module tb_triangle_tangent_from_uv;
  import tfuv_pkg::*;

  localparam int FRAC       = FRAC_BITS_DEF;
  localparam int CYC_LIMIT  = 400000;
  localparam int HOLD_LEN   = 3000;
  localparam int HOLD_AFTER = 60;

  typedef struct {
    longint p[3];
    longint t[2];
  } corner_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  triangle_tangent_from_uv i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  in_t     corner_queue[$];
  out_t    tangent_expect[$];
  corner_t stored_corner[2];
  int      stored_count = 0;
  int      mismatches = 0;
  int      accepted = 0;
  int      cycles = 0;
  bit      req_taken = 1'b0;

  // one tangent component: num * 2^FRAC / det, truncated, saturated
  function automatic logic [31:0] tangent_comp(logic signed [127:0] num,
                                               logic signed [127:0] det);
    logic        neg;
    logic [127:0] mn, md, q, lim;
    neg = num[127] ^ det[127];
    mn  = num[127] ? -num : num;
    md  = det[127] ? -det : det;
    q   = (mn << FRAC) / md;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? -q[31:0] : q[31:0];
  endfunction

  // tangent for one base corner a with the next corners b and c
  function automatic out_t slot_tangent(corner_t a, corner_t b, corner_t c,
                                        logic [1:0] slot);
    out_t r;
    logic signed [127:0] d1u, d1v, d2u, d2v, det, e1, e2, num;
    logic [31:0] t[3];
    d1u = b.t[0] - a.t[0];
    d1v = b.t[1] - a.t[1];
    d2u = c.t[0] - a.t[0];
    d2v = c.t[1] - a.t[1];
    det = d1u * d2v - d2u * d1v;
    for (int k = 0; k < 3; k++) begin
      e1 = b.p[k] - a.p[k];
      e2 = c.p[k] - a.p[k];
      num = d2v * e1 - d1v * e2;
      t[k] = (det == 0) ? 32'd0 : tangent_comp(num, det);
    end
    r.tangent_x        = t[0];
    r.tangent_y        = t[1];
    r.tangent_z        = t[2];
    r.corner_slot      = slot;
    r.degenerate       = (det == 0);
    r.last_of_triangle = (slot == SLOT_LAST);
    return r;
  endfunction

  // store corners, emit three expected tangents on the third
  task automatic predict_corner(in_t d);
    corner_t cur, tri_c[3];
    cur.p[0] = d.pos_x;
    cur.p[1] = d.pos_y;
    cur.p[2] = d.pos_z;
    cur.t[0] = d.tex_u;
    cur.t[1] = d.tex_v;
    if (stored_count < 2) begin
      stored_corner[stored_count] = cur;
      stored_count++;
    end else begin
      stored_count = 0;
      tri_c[0] = stored_corner[0];
      tri_c[1] = stored_corner[1];
      tri_c[2] = cur;
      for (int k = 0; k < 3; k++)
        tangent_expect.push_back(slot_tangent(tri_c[k], tri_c[(k + 1) % 3],
                                              tri_c[(k + 2) % 3], 2'(k)));
    end
  endtask

  function automatic in_t make_corner(int px, int py, int pz, int u, int v);
    in_t c;
    c.pos_x = px;
    c.pos_y = py;
    c.pos_z = pz;
    c.tex_u = u;
    c.tex_v = v;
    return c;
  endfunction

  function automatic int rand_val(int mode);
    case (mode)
      0: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      1: return $signed($urandom_range(0, 1 << 12)) - (1 << 11);
      default: return $urandom;
    endcase
  endfunction

  // sender: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    logic v_next;
    in_t  d_next;
    v_next = in_valid_i;
    d_next = in_data_i;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      v_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (corner_queue.size() > 0) begin
        d_next = corner_queue.pop_front();
        v_next = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_valid_i <= v_next;
    in_data_i  <= d_next;
  end

  // receiver: stall pattern chosen at random from three modes, plus one long hold
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  stall_mode = 0;
  always @(negedge clk_i) begin
    logic s_next;
    if (cycles % 256 == 0) stall_mode = $urandom_range(0, 2);
    if (!hold_done && accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      s_next = 1'b1;
    end else begin
      case (stall_mode)
        0: s_next = 1'b0;
        1: s_next = ($urandom_range(0, 3) == 0);
        default: s_next = ($urandom_range(0, 3) != 0);
      endcase
    end
    out_stall_i <= s_next;
  end

  // monitor: predict on accepted corners, check accepted tangents
  always @(posedge clk_i) begin
    out_t exp_t;
    cycles++;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        req_taken = 1'b1;
        accepted++;
        predict_corner(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (tangent_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected tangent %p", out_data_o);
        end else begin
          exp_t = tangent_expect.pop_front();
          if (out_data_o.tangent_x !== exp_t.tangent_x ||
              out_data_o.tangent_y !== exp_t.tangent_y ||
              out_data_o.tangent_z !== exp_t.tangent_z ||
              out_data_o.corner_slot !== exp_t.corner_slot ||
              out_data_o.degenerate !== exp_t.degenerate ||
              out_data_o.last_of_triangle !== exp_t.last_of_triangle) begin
            mismatches++;
            if (mismatches <= 10)
              $display("tangent mismatch: expected %p actual %p", exp_t, out_data_o);
          end
        end
      end
    end
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int mode, u, v;
    // regular triangle, unit uv
    corner_queue.push_back(make_corner(0, 0, 0, 0, 0));
    corner_queue.push_back(make_corner(32'h10000, 0, 0, 32'h10000, 0));
    corner_queue.push_back(make_corner(0, 32'h10000, 32'h8000, 0, 32'h10000));
    // zero determinant: identical uv
    corner_queue.push_back(make_corner(5, 6, 7, 32'h1234, 32'h5678));
    corner_queue.push_back(make_corner(-5, 60, 7, 32'h1234, 32'h5678));
    corner_queue.push_back(make_corner(9, -6, 70, 32'h1234, 32'h5678));
    // field extremes, saturation in both directions
    corner_queue.push_back(make_corner(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                       0, 0));
    corner_queue.push_back(make_corner(32'h80000000, 32'h7fffffff, 32'h80000000,
                                       1, 0));
    corner_queue.push_back(make_corner(32'h7fffffff, 32'h80000000, 0, 0, 1));
    corner_queue.push_back(make_corner(32'h80000000, 32'h80000000, 32'h80000000,
                                       32'h80000000, 32'h80000000));
    corner_queue.push_back(make_corner(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                       32'h7fffffff, 32'h80000000));
    corner_queue.push_back(make_corner(0, -1, 32'hffffffff, 32'h80000000,
                                       32'h7fffffff));
    // all ones and all zeros
    corner_queue.push_back(make_corner(-1, -1, -1, -1, -1));
    corner_queue.push_back(make_corner(0, 0, 0, 0, 0));
    corner_queue.push_back(make_corner(-1, 0, -1, 0, -1));
    // random triangles: mostly small values, some full range, some degenerate
    for (int n = 0; n < 45; n++) begin
      mode = $urandom_range(0, 5);
      u = rand_val(mode % 3);
      v = rand_val(mode % 3);
      for (int c = 0; c < 3; c++)
        corner_queue.push_back(make_corner(rand_val(mode % 3), rand_val(mode % 3),
          rand_val(mode % 3),
          (mode == 5) ? u : rand_val(mode % 3),
          (mode == 5) ? v + c * 3 * (c - 1) * 0 : rand_val(mode % 3)));
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (corner_queue.size() == 0 && !in_valid_i);
    wait (tangent_expect.size() == 0);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && tangent_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/tfuv_pkg.sv
src/tfuv_ctrl.sv
src/tfuv_dp.sv
src/triangle_tangent_from_uv.sv
test/tb_triangle_tangent_from_uv.sv
